/* rtl/csc_pkg.sv */
// shared types, constants and helpers for the clock second-chance byte cache
package csc_pkg;

	localparam int ENTRY_COUNT_DEF = 32;
	localparam int KEY_BITS_DEF    = 32;
	localparam int CAP_W           = 40;
	localparam int OCC_W           = 41;
	localparam int CNT_W           = 48;
	localparam int SIZE_W          = 32;
	localparam int PADDR_W         = 4;
	localparam int PDATA_W         = 64;
	localparam logic [CAP_W-1:0] CAP_RESET = 40'd5368709120;
	localparam logic REG_CAPACITY = 1'b0;

	// commands from the controller to the datapath
	typedef struct packed {
		logic latch;
		logic srch;
		logic hit;
		logic clr_ref;
		logic step;
		logic rd_hand;
		logic evict;
		logic ins_start;
		logic ptr_dec;
		logic insert;
		logic final_res;
	} csc_cmd_t;

	// status from the datapath to the controller
	typedef struct packed {
		logic match;
		logic srch_done;
		logic bypass;
		logic fits;
		logic hand_valid;
		logic hand_ref;
		logic ptr_free;
	} csc_sts_t;

	function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a,
			input logic [SIZE_W-1:0] b);
		logic [CNT_W:0] s;
		s = {1'b0, a} + (CNT_W+1)'(b);
		return s[CNT_W] ? {CNT_W{1'b1}} : s[CNT_W-1:0];
	endfunction

endpackage

/* rtl/csc_ctrl.sv */
// controller state machine: search, sweep, evict, insert, final result
module csc_ctrl import csc_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  csc_sts_t sts,
	output csc_cmd_t cmd,
	output logic     busy
);

	typedef enum logic [2:0] {
		S_IDLE, S_SRCH, S_SWEEP, S_EVICT, S_INS, S_FIN
	} state_t;

	state_t state_q;
	state_t state_nxt;

	always_comb begin
		cmd = '0;
		state_nxt = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.latch = 1'b1;
					state_nxt = S_SRCH;
				end
			end
			S_SRCH: begin
				cmd.srch = 1'b1;
				if (sts.match) begin
					cmd.hit = 1'b1;
					state_nxt = S_FIN;
				end else if (sts.srch_done) begin
					state_nxt = sts.bypass ? S_FIN : S_SWEEP;
				end
			end
			S_SWEEP: begin
				if (sts.fits) begin
					cmd.ins_start = 1'b1;
					state_nxt = S_INS;
				end else if (sts.hand_valid && sts.hand_ref) begin
					cmd.clr_ref = 1'b1;
				end else if (!sts.hand_valid) begin
					cmd.step = 1'b1;
				end else begin
					cmd.rd_hand = 1'b1;
					state_nxt = S_EVICT;
				end
			end
			S_EVICT: begin
				cmd.evict = 1'b1;
				state_nxt = S_SWEEP;
			end
			S_INS: begin
				if (sts.ptr_free) begin
					cmd.insert = 1'b1;
					state_nxt = S_FIN;
				end else begin
					cmd.ptr_dec = 1'b1;
				end
			end
			S_FIN: begin
				cmd.final_res = 1'b1;
				state_nxt = S_IDLE;
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			busy <= 1'b0;
		end else begin
			state_q <= state_nxt;
			busy <= (state_nxt != S_IDLE);
		end
	end

	a_busy_state: assert property (@(posedge clk) disable iff (!arst_n)
		busy == (state_q != S_IDLE)) else $error("busy out of step with state");
	a_start_only_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.latch |-> !busy) else $error("item latched while busy");
	a_evict_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.evict |-> $past(cmd.rd_hand)) else $error("eviction without slot read");

endmodule

/* rtl/csc_dp.sv */
// datapath: slot memory, valid and reference bits, hand, occupancy, counters, results
module csc_dp import csc_pkg::*; #(
	parameter int ENTRY_COUNT = ENTRY_COUNT_DEF,
	parameter int KEY_BITS    = KEY_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  csc_cmd_t          cmd,
	output csc_sts_t          sts,
	input  logic [31:0]       key,
	input  logic [SIZE_W-1:0] size_bytes,
	input  logic [CAP_W-1:0]  capacity,
	output logic              strobe,
	output logic              is_eviction,
	output logic [31:0]       evicted_key,
	output logic [31:0]       evicted_size,
	output logic              hit,
	output logic              inserted,
	output logic              last,
	output logic [OCC_W-1:0]  occupied_total,
	output logic [CNT_W-1:0]  request_count,
	output logic [CNT_W-1:0]  hit_count,
	output logic [CNT_W-1:0]  byte_total,
	output logic [CNT_W-1:0]  hit_byte_total
);

	localparam int HW = $clog2(ENTRY_COUNT);
	localparam int SW = $clog2(ENTRY_COUNT + 1);
	localparam logic [HW-1:0] LAST_IDX = HW'(ENTRY_COUNT - 1);

	logic [KEY_BITS-1:0] mem_key [ENTRY_COUNT];
	logic [SIZE_W-1:0]   mem_size [ENTRY_COUNT];

	logic [ENTRY_COUNT-1:0] valid_q, ref_q;
	logic [HW-1:0] hand_q, ptr_q, pend_idx_s1;
	logic [SW-1:0] srch_q;
	logic          pend_s1;
	logic [KEY_BITS-1:0] key_q, rd_key_s1;
	logic [SIZE_W-1:0]   size_q, rd_size_s1;
	logic [OCC_W-1:0]    occ_q;
	logic [CNT_W-1:0]    req_q, hits_q, bytes_q, hbytes_q;
	logic                hit_q, ins_q;

	logic [63:0]         key_wide, ev_wide;
	logic [KEY_BITS-1:0] key_m;
	logic [HW-1:0]       hand_nxt, hand_prev, ptr_prev, rd_addr;
	logic                rd_en;
	logic [OCC_W-1:0]    occ_evict;
	logic [OCC_W:0]      need;

	assign key_wide  = 64'(key);
	assign key_m     = key_wide[KEY_BITS-1:0];
	assign ev_wide   = 64'(rd_key_s1);
	assign hand_nxt  = (hand_q == LAST_IDX) ? '0 : hand_q + 1'b1;
	assign hand_prev = (hand_q == '0) ? LAST_IDX : hand_q - 1'b1;
	assign ptr_prev  = (ptr_q == '0) ? LAST_IDX : ptr_q - 1'b1;
	assign rd_en     = (cmd.srch && (srch_q < SW'(ENTRY_COUNT))) || cmd.rd_hand;
	assign rd_addr   = cmd.rd_hand ? hand_q : srch_q[HW-1:0];
	assign occ_evict = occ_q - OCC_W'(rd_size_s1);
	assign need      = {1'b0, occ_q} + (OCC_W+1)'(size_q);

	assign sts.match      = pend_s1 && valid_q[pend_idx_s1] && (rd_key_s1 == key_q);
	assign sts.srch_done  = (srch_q == SW'(ENTRY_COUNT)) && !pend_s1;
	assign sts.bypass     = CAP_W'(size_q) >= capacity;
	assign sts.fits       = (need <= (OCC_W+1)'(capacity)) && !(&valid_q);
	assign sts.hand_valid = valid_q[hand_q];
	assign sts.hand_ref   = ref_q[hand_q];
	assign sts.ptr_free   = !valid_q[ptr_q];

	// slot memory, registered read
	always_ff @(posedge clk) begin
		if (cmd.insert) begin
			mem_key[ptr_q]  <= key_q;
			mem_size[ptr_q] <= size_q;
		end
		if (rd_en) begin
			rd_key_s1  <= mem_key[rd_addr];
			rd_size_s1 <= mem_size[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			key_q  <= key_m;
			size_q <= size_bytes;
		end
		if (cmd.srch) pend_idx_s1 <= srch_q[HW-1:0];
		if (cmd.ins_start) ptr_q <= hand_prev;
		else if (cmd.ptr_dec) ptr_q <= ptr_prev;
		if (cmd.evict) begin
			is_eviction    <= 1'b1;
			evicted_key    <= ev_wide[31:0];
			evicted_size   <= rd_size_s1;
			hit            <= 1'b0;
			inserted       <= 1'b0;
			last           <= 1'b0;
			occupied_total <= occ_evict;
		end else begin
			is_eviction    <= 1'b0;
			evicted_key    <= '0;
			evicted_size   <= '0;
			hit            <= hit_q;
			inserted       <= ins_q;
			last           <= 1'b1;
			occupied_total <= occ_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			ref_q    <= '0;
			hand_q   <= '0;
			occ_q    <= '0;
			req_q    <= '0;
			hits_q   <= '0;
			bytes_q  <= '0;
			hbytes_q <= '0;
			srch_q   <= '0;
			pend_s1  <= 1'b0;
			hit_q    <= 1'b0;
			ins_q    <= 1'b0;
			strobe   <= 1'b0;
		end else begin
			strobe <= cmd.evict || cmd.final_res;
			if (cmd.latch) begin
				req_q   <= sat_add(req_q, SIZE_W'(1));
				bytes_q <= sat_add(bytes_q, size_bytes);
				srch_q  <= '0;
				pend_s1 <= 1'b0;
				hit_q   <= 1'b0;
				ins_q   <= 1'b0;
			end
			if (cmd.srch) begin
				pend_s1 <= (srch_q < SW'(ENTRY_COUNT));
				if (srch_q < SW'(ENTRY_COUNT)) srch_q <= srch_q + 1'b1;
			end
			if (cmd.hit) begin
				ref_q[pend_idx_s1] <= 1'b1;
				hit_q    <= 1'b1;
				hits_q   <= sat_add(hits_q, SIZE_W'(1));
				hbytes_q <= sat_add(hbytes_q, size_q);
			end
			if (cmd.clr_ref) begin
				ref_q[hand_q] <= 1'b0;
				hand_q <= hand_nxt;
			end
			if (cmd.step) hand_q <= hand_nxt;
			if (cmd.evict) begin
				valid_q[hand_q] <= 1'b0;
				occ_q  <= occ_evict;
				hand_q <= hand_nxt;
			end
			if (cmd.insert) begin
				valid_q[ptr_q] <= 1'b1;
				ref_q[ptr_q]   <= 1'b0;
				occ_q <= OCC_W'(need);
				ins_q <= 1'b1;
			end
		end
	end

	assign request_count  = req_q;
	assign hit_count      = hits_q;
	assign byte_total     = bytes_q;
	assign hit_byte_total = hbytes_q;

	a_hand_range: assert property (@(posedge clk) disable iff (!arst_n)
		hand_q <= LAST_IDX) else $error("hand out of range");
	a_insert_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.insert |=> valid_q[$past(ptr_q)] && !ref_q[$past(ptr_q)])
		else $error("insert did not claim its slot");
	a_last_once: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && last |=> !strobe) else $error("result after final result");

endmodule

/* rtl/clock_second_chance_byte_cache.sv */
// top level: apb capacity register, controller and datapath of the clock cache
//
//  channel   signals                               handshake
//  request   key, size_bytes                       start high while busy low
//  result    is_eviction .. hit_byte_total         strobe high for one cycle
//  config    psel penable pwrite paddr pwdata      write at access phase, pready=1
//
// a request searches the ENTRY_COUNT slots one per cycle until a match, and a hit
// or bypass then finishes; a miss then sweeps the hand one slot per cycle, apart
// from each eviction, which reads the slot through the slot memory read port,
// and walks back to a free slot one per cycle.
// reset clears all valid and reference bits at once; no clearing pass.
// one eviction result per evicted entry, then one final result; results cannot stall.
module clock_second_chance_byte_cache import csc_pkg::*; #(
	parameter int ENTRY_COUNT = ENTRY_COUNT_DEF,
	parameter int KEY_BITS    = KEY_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [31:0]        key,
	input  logic [SIZE_W-1:0]  size_bytes,
	output logic               strobe,
	output logic               is_eviction,
	output logic [31:0]        evicted_key,
	output logic [31:0]        evicted_size,
	output logic               hit,
	output logic               inserted,
	output logic               last,
	output logic [OCC_W-1:0]   occupied_total,
	output logic [CNT_W-1:0]   request_count,
	output logic [CNT_W-1:0]   hit_count,
	output logic [CNT_W-1:0]   byte_total,
	output logic [CNT_W-1:0]   hit_byte_total,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready
);

	logic [CAP_W-1:0] cap_q;
	csc_cmd_t cmd;
	csc_sts_t sts;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (psel && penable && pwrite && (paddr[3] == REG_CAPACITY)) begin
			cap_q <= pwdata[CAP_W-1:0];
		end
	end

	always_comb begin
		unique case (paddr[3])
			REG_CAPACITY: prdata = PDATA_W'(cap_q);
			default:      prdata = '0;
		endcase
	end

	csc_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy)
	);

	csc_dp #(
		.ENTRY_COUNT (ENTRY_COUNT),
		.KEY_BITS    (KEY_BITS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.key            (key),
		.size_bytes     (size_bytes),
		.capacity       (cap_q),
		.strobe         (strobe),
		.is_eviction    (is_eviction),
		.evicted_key    (evicted_key),
		.evicted_size   (evicted_size),
		.hit            (hit),
		.inserted       (inserted),
		.last           (last),
		.occupied_total (occupied_total),
		.request_count  (request_count),
		.hit_count      (hit_count),
		.byte_total     (byte_total),
		.hit_byte_total (hit_byte_total)
	);

endmodule
